// ----- design/fpn_pkg.sv -----
// Package for the fractal Perlin noise stream generator.
// Holds request codes, register indexes, field widths and the Q1.15 saturation helper.
// No dependencies.
package fpn_pkg;

  // Request codes carried in the input tuser field.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_GEN     = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_STEP    = 2'd0;
  localparam logic [1:0] REG_OCTAVES = 2'd1;
  localparam logic [1:0] REG_PERSIST = 2'd2;
  localparam logic [1:0] REG_LACUN   = 2'd3;

  // Field widths.
  localparam int CNT_W  = 7;
  localparam int IDX_W  = 16;
  localparam int GRAD_W = 16;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Saturate a sign and a 17-bit magnitude to Q1.15.
  function automatic logic signed [15:0] sat_q15(input logic neg, input logic [16:0] mag);
    logic signed [15:0] res;
    if (neg) begin
      res = (mag > 17'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, mag}));
    end else begin
      res = (mag > 17'd32767) ? 16'sh7fff : $signed(mag[15:0]);
    end
    return res;
  endfunction

endpackage

// ----- design/fpn_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; no package needed.
module fpn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- design/fpn_mul.sv -----
// Shared signed multiplier with a registered product.
// Uses fpn_pkg for operand and product widths.
module fpn_mul
  import fpn_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  // One product per cycle, registered.
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

// ----- design/fpn_div.sv -----
// Iterative restoring divider: octave total over amplitude sum, saturated to Q1.15.
// Uses fpn_pkg for the saturation helper. One quotient bit per cycle, 17 bits.
module fpn_div
  import fpn_pkg::*;
#(
  parameter int TW  = 41,
  parameter int ASW = 21
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [TW-1:0]  total_i,
  input  logic [ASW-1:0]        asum_i,
  output logic                  done_o,
  output logic signed [15:0]    sample_o
);

  localparam int DW = ASW + 16;

  logic              busy_q;
  logic              done_q;
  logic [4:0]        cnt_q;
  logic [TW-1:0]     rem_q;
  logic [DW-1:0]     dsh_q;
  logic [16:0]       quo_q;
  logic              neg_q;
  logic signed [15:0] res_q;

  logic [TW-1:0]     mag;
  logic              sat;
  logic              fits;
  logic [16:0]       quo_d;

  // Magnitude of the total and the overflow check against the divisor shifted by 17.
  always_comb begin
    mag   = total_i[TW-1] ? TW'(-total_i) : TW'(total_i);
    sat   = mag >= TW'({asum_i, 17'd0});
    fits  = rem_q >= TW'(dsh_q);
    quo_d = {quo_q[15:0], fits};
  end

  // Divider sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (sat) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= 5'd17;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: one compare and subtract per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= total_i[TW-1];
      rem_q <= mag;
      dsh_q <= {asum_i, 16'd0};
      quo_q <= 17'd0;
      if (sat) begin
        res_q <= total_i[TW-1] ? 16'sh8000 : 16'sh7fff;
      end
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - TW'(dsh_q);
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= quo_d;
      if (cnt_q == 5'd1) begin
        res_q <= sat_q15(neg_q, quo_d);
      end
    end
  end

  assign done_o   = done_q;
  assign sample_o = res_q;

endmodule

// ----- design/fractal_perlin_noise_1d_stream.sv -----
// Top level of the fractal Perlin noise stream generator.
// Uses fpn_pkg, fpn_ram (gradient table), fpn_mul (shared multiplier), fpn_div.
//
// Usage:
//   The input stream carries requests: tuser holds the request code, tdata the
//   sample count, the gradient index and the gradient value. A load writes one
//   gradient entry, a restart sets the position to zero, a generate emits
//   sample_count samples (at most MAX_BURST) on the output stream, the final one
//   marked with tlast. A request is taken only while the generator is idle.
//   Each sample runs every octave on the single shared multiplier, used in turn
//   for every product, then the bit-serial divider (which skips its steps when
//   the quotient saturates), and then hands the beat to the output register.
//   When the receiver stalls, the sequencer holds the finished sample until the
//   output register frees up; nothing is dropped.
//   Configuration registers are written through a plain write port; the user must write them
//   only while idle, as the block does not enforce it. Reset clears the position, sets the
//   registers to their defaults and empties the output register. The gradient table is not
//   cleared; entries must be loaded before they are used.
module fractal_perlin_noise_1d_stream
  import fpn_pkg::*;
#(
  parameter int TABLE_SIZE  = 65536,
  parameter int MAX_OCTAVES = 8,
  parameter int MAX_BURST   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // sample_count[6:0], grad_index[22:7], grad_value[38:23]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  // Sample stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // sample[15:0]
  output logic        m_axis_tlast
);

  localparam int AW  = $clog2(TABLE_SIZE);
  localparam int OW  = $clog2(MAX_OCTAVES + 1);
  localparam int ASW = 17 + OW;
  localparam int TW  = ASW + 20;
  localparam int RW  = 52;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POS   = 4'd1;
  localparam logic [3:0] S_CELL  = 4'd2;
  localparam logic [3:0] S_G0    = 4'd3;
  localparam logic [3:0] S_G1    = 4'd4;
  localparam logic [3:0] S_F     = 4'd5;
  localparam logic [3:0] S_TG0   = 4'd6;
  localparam logic [3:0] S_TERM0 = 4'd7;
  localparam logic [3:0] S_TG1   = 4'd8;
  localparam logic [3:0] S_TERM1 = 4'd9;
  localparam logic [3:0] S_ACC   = 4'd10;
  localparam logic [3:0] S_AMP   = 4'd11;
  localparam logic [3:0] S_FREQ  = 4'd12;
  localparam logic [3:0] S_DIV   = 4'd13;
  localparam logic [3:0] S_EMIT  = 4'd14;

  // Request fields.
  logic [1:0]              op;
  logic [CNT_W-1:0]        req_count;
  logic [IDX_W-1:0]        grad_index;
  logic [GRAD_W-1:0]       grad_value;
  assign op         = s_axis_tuser;
  assign req_count  = s_axis_tdata[6:0];
  assign grad_index = s_axis_tdata[22:7];
  assign grad_value = s_axis_tdata[38:23];

  // Configuration and state registers.
  logic [31:0]             step_q;
  logic [3:0]              oct_cfg_q;
  logic [15:0]             pers_q;
  logic [14:0]             lac_q;
  logic [31:0]             pos_q;
  logic [3:0]              state_q, state_d;
  logic [CNT_W-1:0]        remain_q;
  logic [OW-1:0]           oct_q;
  logic [31:0]             freq_q;
  logic [16:0]             amp_q;
  logic signed [TW-1:0]    total_q;
  logic [ASW-1:0]          asum_q;
  logic [15:0]             t_q;
  logic [AW-1:0]           cell_q;
  logic [15:0]             u_q;
  logic [16:0]             f_q;
  logic signed [15:0]      g0_q;
  logic signed [15:0]      g1_q;
  logic signed [RW-1:0]    raw_q;
  logic                    out_valid_q;
  logic [15:0]             out_data_q;
  logic                    out_last_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic [AW-1:0]            raddr;
  logic [GRAD_W-1:0]        rdata;
  logic                     accept;
  logic                     load_we;
  logic [CNT_W-1:0]         burst;
  logic [OW-1:0]            oct_lim;
  logic [20:0]              fade_p;
  logic signed [RW-1:0]     raw_sum;
  logic signed [RW-1:0]     raw_adj;
  logic                     div_start;
  logic                     div_done;
  logic signed [15:0]       div_sample;
  logic                     out_free;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign load_we = accept && (op == OP_LOAD) && ({1'b0, grad_index} < 17'(TABLE_SIZE));
  assign burst   = (req_count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : req_count;
  assign out_free = !out_valid_q || m_axis_tready;

  // Effective octave count: zero acts as one, large counts are limited.
  always_comb begin
    if (oct_cfg_q == 4'd0) begin
      oct_lim = OW'(1);
    end else if ({1'b0, oct_cfg_q} > 5'(MAX_OCTAVES)) begin
      oct_lim = OW'(MAX_OCTAVES);
    end else begin
      oct_lim = OW'(oct_cfg_q);
    end
  end

  // Fade polynomial term 6u - 15t + 10.0, always positive.
  assign fade_p = 21'(u_q) * 21'd6 + 21'd655360 - 21'(t_q) * 21'd15;

  // Both interpolation terms summed, then divided by 2^32 toward zero.
  assign raw_sum = raw_q + RW'(prod_q);
  assign raw_adj = raw_sum + (raw_sum[RW-1] ? RW'(64'hFFFF_FFFF) : RW'(0));

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_POS: begin
        mul_a = $signed({1'b0, pos_q});
        mul_b = $signed({1'b0, freq_q});
      end
      S_CELL: begin
        mul_a = $signed(MUL_W'(prod_q[31:16]));
        mul_b = $signed(MUL_W'(prod_q[31:16]));
      end
      S_G0: begin
        mul_a = $signed({1'b0, prod_q[31:0]});
        mul_b = $signed(MUL_W'(t_q));
      end
      S_G1: begin
        mul_a = $signed(MUL_W'(prod_q[47:32]));
        mul_b = $signed(MUL_W'(fade_p));
      end
      S_F: begin
        mul_a = $signed(MUL_W'(t_q));
        mul_b = MUL_W'(g0_q);
      end
      S_TG0: begin
        mul_a = $signed(MUL_W'(17'h10000 - f_q));
        mul_b = $signed(prod_q[MUL_W-1:0]);
      end
      S_TERM0: begin
        mul_a = $signed(MUL_W'(t_q)) - $signed(MUL_W'(17'h10000));
        mul_b = MUL_W'(g1_q);
      end
      S_TG1: begin
        mul_a = $signed(MUL_W'(f_q));
        mul_b = $signed(prod_q[MUL_W-1:0]);
      end
      S_TERM1: begin
        mul_a = MUL_W'($signed(raw_adj[RW-1:32]));
        mul_b = $signed(MUL_W'(amp_q));
      end
      S_ACC: begin
        mul_a = $signed(MUL_W'(amp_q));
        mul_b = $signed(MUL_W'(pers_q));
      end
      S_AMP: begin
        mul_a = $signed({1'b0, freq_q});
        mul_b = $signed(MUL_W'(lac_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Table read address: cell in one cycle, cell plus one in the next.
  always_comb begin
    case (state_q)
      S_CELL:  raddr = prod_q[32 +: AW];
      default: raddr = cell_q + AW'(1);
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (op == OP_GEN) && (burst != '0)) begin
          state_d = S_POS;
        end
      end
      S_POS:   state_d = S_CELL;
      S_CELL:  state_d = S_G0;
      S_G0:    state_d = S_G1;
      S_G1:    state_d = S_F;
      S_F:     state_d = S_TG0;
      S_TG0:   state_d = S_TERM0;
      S_TERM0: state_d = S_TG1;
      S_TG1:   state_d = S_TERM1;
      S_TERM1: state_d = S_ACC;
      S_ACC:   state_d = S_AMP;
      S_AMP:   state_d = S_FREQ;
      S_FREQ:  state_d = (oct_q + OW'(1) == oct_lim) ? S_DIV : S_POS;
      S_DIV:   state_d = div_done ? S_EMIT : S_DIV;
      S_EMIT: begin
        if (out_free) begin
          state_d = (remain_q == CNT_W'(1)) ? S_IDLE : S_POS;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign div_start = (state_q == S_FREQ) && (oct_q + OW'(1) == oct_lim);

  // Control registers, configuration and position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= 32'd65;
      oct_cfg_q   <= 4'd4;
      pers_q      <= 16'd32768;
      lac_q       <= 15'd8192;
      pos_q       <= 32'd0;
      remain_q    <= '0;
      oct_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_STEP:    step_q    <= cfg_wdata_i;
          REG_OCTAVES: oct_cfg_q <= cfg_wdata_i[3:0];
          REG_PERSIST: pers_q    <= cfg_wdata_i[15:0];
          REG_LACUN:   lac_q     <= cfg_wdata_i[14:0];
          default: ;
        endcase
      end
      if (accept && (op == OP_RESTART)) begin
        pos_q <= 32'd0;
      end
      if (accept && (op == OP_GEN)) begin
        remain_q <= burst;
        oct_q    <= '0;
      end
      if (state_q == S_FREQ) begin
        oct_q <= (state_d == S_DIV) ? '0 : oct_q + OW'(1);
      end
      if ((state_q == S_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
        pos_q       <= pos_q + step_q;
        remain_q    <= remain_q - CNT_W'(1);
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Octave datapath registers.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) || (state_q == S_EMIT)) begin
      freq_q  <= 32'h0001_0000;
      amp_q   <= 17'h10000;
      total_q <= '0;
      asum_q  <= '0;
    end
    case (state_q)
      S_CELL: begin
        t_q    <= prod_q[31:16];
        cell_q <= prod_q[32 +: AW];
      end
      S_G0: begin
        g0_q <= $signed(rdata);
        u_q  <= prod_q[31:16];
      end
      S_G1: g1_q <= $signed(rdata);
      S_F:  f_q  <= (prod_q[35:16] > 20'h10000) ? 17'h10000 : prod_q[32:16];
      S_TERM0: raw_q <= RW'(prod_q);
      S_ACC: begin
        total_q <= total_q + $signed(prod_q[TW-1:0]);
        asum_q  <= asum_q + ASW'(amp_q);
      end
      S_AMP: amp_q <= prod_q[32:16];
      S_FREQ: freq_q <= (prod_q[46:44] != 3'd0) ? 32'hFFFF_FFFF : prod_q[43:12];
      default: ;
    endcase
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_EMIT) && out_free) begin
      out_data_q <= div_sample;
      out_last_q <= (remain_q == CNT_W'(1));
    end
  end

  fpn_ram #(
    .WIDTH (GRAD_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (grad_index[AW-1:0]),
    .wdata_i (grad_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  fpn_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod_q)
  );

  fpn_div #(
    .TW  (TW),
    .ASW (ASW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .total_i  (total_q),
    .asum_i   (asum_q),
    .done_o   (div_done),
    .sample_o (div_sample)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
